@@ rtl/rcc_pkg.sv @@
// ----------------------------------------------------------------------------
// rcc_pkg
// shared types, codes and helper functions for the rgb color classifier
// ----------------------------------------------------------------------------
package rcc_pkg;

  typedef logic signed [15:0] chan_t;

  typedef enum logic [2:0] {
    CLASS_UNKNOWN = 3'd0,
    CLASS_RED     = 3'd1,
    CLASS_BLUE    = 3'd2,
    CLASS_GREEN   = 3'd3,
    CLASS_BLACK   = 3'd4,
    CLASS_WHITE   = 3'd5
  } color_class_t;

  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_RED_OFFSET   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GREEN_OFFSET = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BLUE_OFFSET  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RED_GAIN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BLUE_GAIN    = 3'd4;

  localparam logic [15:0] RED_GAIN_RESET  = 16'd5530;
  localparam logic [15:0] BLUE_GAIN_RESET = 16'd4096;

  // rescale numerator width: |chan| * 250 stays below 2^23
  localparam int NUM_W = 23;
  localparam int DEN_W = 15;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic             neg;
    chan_t            orig;
  } div_lane_t;

  function automatic chan_t sat16(input logic signed [33:0] v);
    chan_t res;
    if (v > 34'sd32767) res = 16'sh7FFF;
    else if (v < -34'sd32768) res = 16'sh8000;
    else res = v[15:0];
    return res;
  endfunction

  function automatic chan_t max3(input chan_t a, input chan_t b, input chan_t c);
    chan_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic chan_t min3(input chan_t a, input chan_t b, input chan_t c);
    chan_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  // floor(mag / 5) for mag below 2^17, by reciprocal multiply
  function automatic logic [15:0] div5(input logic [16:0] mag);
    logic [33:0] p;
    p = 34'(mag) * 34'd52429;
    return p[33:18];
  endfunction

endpackage

@@ rtl/rcc_front.sv @@
// ----------------------------------------------------------------------------
// rcc_front
// dark offset removal, white balance gains and rescale operand setup
// ----------------------------------------------------------------------------
module rcc_front #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [15:0]        raw_red,
  input  logic [15:0]        raw_green,
  input  logic [15:0]        raw_blue,
  input  logic [15:0]        red_offset,
  input  logic [15:0]        green_offset,
  input  logic [15:0]        blue_offset,
  input  logic [15:0]        red_gain,
  input  logic [15:0]        blue_gain,
  output logic               out_valid,
  output rcc_pkg::div_lane_t lane_r,
  output rcc_pkg::div_lane_t lane_g,
  output rcc_pkg::div_lane_t lane_b,
  output logic [rcc_pkg::DEN_W-1:0] den,
  output logic               scale
);
  import rcc_pkg::*;

  localparam logic signed [32:0] ROUND_BIAS = 33'((34'd1 << GAIN_FRAC_BITS) - 34'd1);

  logic  s1_valid, s2_valid;
  chan_t s1_r, s1_g, s1_b;
  chan_t s2_r, s2_g, s2_b;

  logic signed [17:0] d_r, d_g, d_b;
  logic signed [32:0] prod_r, prod_b, adj_r, adj_b, q_r, q_b;
  chan_t m;
  logic [15:0] mag_r, mag_g, mag_b;

  // stage 1: offsets
  assign d_r = $signed({2'b00, raw_red})   - $signed({2'b00, red_offset});
  assign d_g = $signed({2'b00, raw_green}) - $signed({2'b00, green_offset});
  assign d_b = $signed({2'b00, raw_blue})  - $signed({2'b00, blue_offset});

  always_ff @(posedge clk) begin
    s1_r <= sat16(34'(d_r));
    s1_g <= sat16(34'(d_g));
    s1_b <= sat16(34'(d_b));
  end

  // stage 2: gains, truncated toward zero
  assign prod_r = $signed({{17{s1_r[15]}}, s1_r}) * $signed({17'b0, red_gain});
  assign prod_b = $signed({{17{s1_b[15]}}, s1_b}) * $signed({17'b0, blue_gain});
  assign adj_r  = prod_r + (prod_r[32] ? ROUND_BIAS : 33'sd0);
  assign adj_b  = prod_b + (prod_b[32] ? ROUND_BIAS : 33'sd0);
  assign q_r    = adj_r >>> GAIN_FRAC_BITS;
  assign q_b    = adj_b >>> GAIN_FRAC_BITS;

  always_ff @(posedge clk) begin
    s2_r <= sat16(34'(q_r));
    s2_g <= s1_g;
    s2_b <= sat16(34'(q_b));
  end

  // stage 3: largest channel and rescale numerators
  assign m     = max3(s2_r, s2_g, s2_b);
  assign mag_r = s2_r[15] ? 16'(-s2_r) : 16'(s2_r);
  assign mag_g = s2_g[15] ? 16'(-s2_g) : 16'(s2_g);
  assign mag_b = s2_b[15] ? 16'(-s2_b) : 16'(s2_b);

  always_ff @(posedge clk) begin
    lane_r <= '{num: NUM_W'(mag_r) * NUM_W'(250), neg: s2_r[15], orig: s2_r};
    lane_g <= '{num: NUM_W'(mag_g) * NUM_W'(250), neg: s2_g[15], orig: s2_g};
    lane_b <= '{num: NUM_W'(mag_b) * NUM_W'(250), neg: s2_b[15], orig: s2_b};
    den    <= m[DEN_W-1:0];
    scale  <= (m > 16'sd255);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

endmodule

@@ rtl/rcc_div_lane.sv @@
// ----------------------------------------------------------------------------
// rcc_div_lane
// two stage restoring divider for the 250/max rescale of one channel
// ----------------------------------------------------------------------------
module rcc_div_lane (
  input  logic                      clk,
  input  rcc_pkg::div_lane_t        lane,
  input  logic [rcc_pkg::DEN_W-1:0] den,
  input  logic                      scale,
  output rcc_pkg::chan_t            value
);
  import rcc_pkg::*;

  logic [DEN_W-1:0] a_rem, a_den;
  logic [7:0]       a_qhi;
  logic [6:0]       a_low;
  logic             a_neg, a_scale;
  chan_t            a_orig;

  logic [15:0] rem_a, rem_b;
  logic [7:0]  qhi;
  logic [6:0]  qlo;
  logic signed [15:0] qs;

  // quotient bits 14..7; den is at least 256 so the top byte never divides
  always_comb begin
    rem_a = {8'b0, lane.num[22:15]};
    qhi   = '0;
    for (int i = 0; i < 8; i++) begin
      rem_a = {rem_a[14:0], lane.num[14-i]};
      if (rem_a >= {1'b0, den}) begin
        rem_a     = rem_a - {1'b0, den};
        qhi[7-i]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_rem   <= rem_a[DEN_W-1:0];
    a_den   <= den;
    a_qhi   <= qhi;
    a_low   <= lane.num[6:0];
    a_neg   <= lane.neg;
    a_scale <= scale;
    a_orig  <= lane.orig;
  end

  // quotient bits 6..0
  always_comb begin
    rem_b = {1'b0, a_rem};
    qlo   = '0;
    for (int i = 0; i < 7; i++) begin
      rem_b = {rem_b[14:0], a_low[6-i]};
      if (rem_b >= {1'b0, a_den}) begin
        rem_b    = rem_b - {1'b0, a_den};
        qlo[6-i] = 1'b1;
      end
    end
  end

  assign qs = $signed({1'b0, a_qhi, qlo});

  always_ff @(posedge clk) begin
    if (a_scale) value <= a_neg ? -qs : qs;
    else value <= a_orig;
  end

endmodule

@@ rtl/rcc_band.sv @@
// ----------------------------------------------------------------------------
// rcc_band
// band attenuation with orange, pink and yellow corrections
// ----------------------------------------------------------------------------
module rcc_band (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  rcc_pkg::chan_t in_r,
  input  rcc_pkg::chan_t in_g,
  input  rcc_pkg::chan_t in_b,
  output logic           out_valid,
  output rcc_pkg::chan_t out_r,
  output rcc_pkg::chan_t out_g,
  output rcc_pkg::chan_t out_b
);
  import rcc_pkg::*;

  typedef struct packed {
    logic [16:0] mag;
    logic        neg;
    logic        go;
    chan_t       raw;
  } div5_op_t;

  logic [4:0] vld;

  // stage 1 registers
  chan_t a_r, a_g, a_b, a_m;
  logic  a_rmid, a_rlow, a_gmid, a_glow, a_bmid, a_blow, a_orange, a_pink;
  // stage 2
  div5_op_t b_r, b_g, b_b;
  chan_t    b_m;
  // stage 3
  chan_t c_r, c_g, c_b, c_m;
  // stage 4
  chan_t d_r, d_g, d_b, d_m;
  logic  d_fix;
  logic [16:0] d_bmag;

  chan_t m;
  logic signed [19:0] r10, g10, b10, m8, m6;
  logic orange, pink;

  assign m   = max3(in_r, in_g, in_b);
  assign r10 = 20'(in_r) * 20'sd10;
  assign g10 = 20'(in_g) * 20'sd10;
  assign b10 = 20'(in_b) * 20'sd10;
  assign m8  = 20'(m) * 20'sd8;
  assign m6  = 20'(m) * 20'sd6;

  assign orange = (m == in_r) && (18'(in_g) >= 18'(in_b) * 18'sd2)
                  && (g10 >= 20'(in_r) * 20'sd2);
  assign pink   = (m == in_r) && (in_g <= in_b) && (b10 >= 20'(in_r) * 20'sd2);

  always_ff @(posedge clk) begin
    a_r      <= in_r;
    a_g      <= in_g;
    a_b      <= in_b;
    a_m      <= m;
    a_rmid   <= (r10 < m8) && (r10 >= m6);
    a_rlow   <= (r10 < m6);
    a_gmid   <= (g10 < m8) && (g10 >= m6);
    a_glow   <= (g10 < m6);
    a_bmid   <= (b10 < m8) && (b10 >= m6) && (in_b > 16'sd125);
    a_blow   <= (b10 < m6);
    a_orange <= orange;
    a_pink   <= pink;
  end

  // stage 2: numerators of the divide by five
  logic signed [17:0] nr, ng, nb;
  chan_t g5, bh, b1, b5;

  assign g5 = sat16(34'(19'(a_g) * 19'sd5));
  assign bh = $signed(a_b + 16'(a_b[15])) >>> 1;
  assign b1 = a_orange ? bh : a_b;
  assign b5 = sat16(34'(19'(b1) * 19'sd5));

  always_comb begin
    nr = a_rmid ? 18'(a_r) * 18'sd2 : 18'(a_r);
    ng = a_gmid ? 18'(a_g) * 18'sd2 : (a_orange ? 18'(g5) : 18'(a_g));
    nb = a_bmid ? 18'(a_b) * 18'sd2 : (a_pink ? 18'(b5) : 18'(b1));
  end

  always_ff @(posedge clk) begin
    b_r <= '{mag: nr[17] ? 17'(-nr) : 17'(nr), neg: nr[17], go: a_rmid | a_rlow, raw: a_r};
    b_g <= '{mag: ng[17] ? 17'(-ng) : 17'(ng), neg: ng[17], go: a_gmid | a_glow, raw: a_g};
    b_b <= '{mag: nb[17] ? 17'(-nb) : 17'(nb), neg: nb[17], go: a_bmid | a_blow, raw: a_b};
    b_m <= a_m;
  end

  // stage 3: divide by five, toward zero
  function automatic chan_t apply5(input div5_op_t op);
    chan_t q;
    q = $signed(div5(op.mag));
    if (!op.go) return op.raw;
    return op.neg ? -q : q;
  endfunction

  always_ff @(posedge clk) begin
    c_r <= apply5(b_r);
    c_g <= apply5(b_g);
    c_b <= apply5(b_b);
    c_m <= b_m;
  end

  // stage 4: yellow correction test
  chan_t mn;
  logic signed [23:0] r100, m85;
  logic signed [17:0] b2;

  assign mn   = min3(c_r, c_g, c_b);
  assign r100 = 24'(c_r) * 24'sd100;
  assign m85  = 24'(c_m) * 24'sd85;
  assign b2   = 18'(c_b) * 18'sd2;

  always_ff @(posedge clk) begin
    d_r    <= c_r;
    d_g    <= c_g;
    d_b    <= c_b;
    d_m    <= c_m;
    d_fix  <= (c_m == c_g) && (r100 >= m85) && (mn == c_b);
    d_bmag <= b2[17] ? 17'(-b2) : 17'(b2);
  end

  // stage 5
  chan_t bq;
  assign bq = $signed(div5(d_bmag));

  always_ff @(posedge clk) begin
    out_r <= d_fix ? d_m : d_r;
    out_g <= d_g;
    out_b <= d_fix ? (d_b[15] ? -bq : bq) : d_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_valid};
    end
  end

  assign out_valid = vld[4];

endmodule

@@ rtl/rcc_classify.sv @@
// ----------------------------------------------------------------------------
// rcc_classify
// xyz conversion and chromaticity window tests
// ----------------------------------------------------------------------------
module rcc_classify (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  rcc_pkg::chan_t in_r,
  input  rcc_pkg::chan_t in_g,
  input  rcc_pkg::chan_t in_b,
  output logic           out_valid,
  output rcc_pkg::chan_t out_r,
  output rcc_pkg::chan_t out_g,
  output rcc_pkg::chan_t out_b,
  output rcc_pkg::color_class_t out_class
);
  import rcc_pkg::*;

  localparam int NW = 5;
  localparam logic [9:0] XLO [NW] = '{10'd520, 10'd90,  10'd235, 10'd290, 10'd290};
  localparam logic [9:0] XHI [NW] = '{10'd700, 10'd220, 10'd302, 10'd340, 10'd328};
  localparam logic [9:0] YLO [NW] = '{10'd250, 10'd90,  10'd349, 10'd440, 10'd300};
  localparam logic [9:0] YHI [NW] = '{10'd450, 10'd250, 10'd800, 10'd800, 10'd345};

  logic [3:0] vld;

  // stage 1: products
  logic signed [29:0] xr, xg, xb, yr, yg, yb, sr, sg, sb;
  chan_t p1_r, p1_g, p1_b;

  always_ff @(posedge clk) begin
    xr <= 30'(in_r) * 30'sd4124;
    xg <= 30'(in_g) * 30'sd3576;
    xb <= 30'(in_b) * 30'sd1805;
    yr <= 30'(in_r) * 30'sd2126;
    yg <= 30'(in_g) * 30'sd7152;
    yb <= 30'(in_b) * 30'sd720;
    sr <= 30'(in_r) * 30'sd6443;
    sg <= 30'(in_g) * 30'sd11920;
    sb <= 30'(in_b) * 30'sd12030;
    p1_r <= in_r;
    p1_g <= in_g;
    p1_b <= in_b;
  end

  // stage 2: sums, sign normalized so the sum is not negative
  logic signed [31:0] xs, ys, ss;
  logic signed [31:0] p2_x, p2_y, p2_s;
  chan_t p2_r, p2_g, p2_b;

  assign xs = 32'(xr) + 32'(xg) + 32'(xb);
  assign ys = 32'(yr) + 32'(yg) + 32'(yb);
  assign ss = 32'(sr) + 32'(sg) + 32'(sb);

  always_ff @(posedge clk) begin
    p2_x <= ss[31] ? -xs : xs;
    p2_y <= ss[31] ? -ys : ys;
    p2_s <= ss[31] ? -ss : ss;
    p2_r <= p1_r;
    p2_g <= p1_g;
    p2_b <= p1_b;
  end

  // stage 3: cross products
  logic signed [43:0] p3_x, p3_y;
  logic signed [43:0] p3_xlo [NW];
  logic signed [43:0] p3_xhi [NW];
  logic signed [43:0] p3_ylo [NW];
  logic signed [43:0] p3_yhi [NW];
  logic p3_nz;
  chan_t p3_r, p3_g, p3_b;

  always_ff @(posedge clk) begin
    p3_x <= 44'(p2_x) * 44'sd1000;
    p3_y <= 44'(p2_y) * 44'sd1000;
    for (int w = 0; w < NW; w++) begin
      p3_xlo[w] <= 44'(p2_s) * $signed({34'b0, XLO[w]});
      p3_xhi[w] <= 44'(p2_s) * $signed({34'b0, XHI[w]});
      p3_ylo[w] <= 44'(p2_s) * $signed({34'b0, YLO[w]});
      p3_yhi[w] <= 44'(p2_s) * $signed({34'b0, YHI[w]});
    end
    p3_nz <= (p2_s != 32'sd0);
    p3_r  <= p2_r;
    p3_g  <= p2_g;
    p3_b  <= p2_b;
  end

  // stage 4: window hits and priority
  logic [NW-1:0] hit;
  color_class_t cls;

  always_comb begin
    for (int w = 0; w < NW; w++) begin
      hit[w] = (p3_xlo[w] < p3_x) && (p3_x < p3_xhi[w])
               && (p3_ylo[w] < p3_y) && (p3_y < p3_yhi[w]);
    end
    cls = CLASS_UNKNOWN;
    if (p3_nz) begin
      if (hit[0]) cls = CLASS_RED;
      else if (hit[1]) cls = CLASS_BLUE;
      else if (hit[2] || hit[3]) cls = CLASS_GREEN;
      else if (hit[4]) cls = (p3_g < 16'sd100) ? CLASS_BLACK : CLASS_WHITE;
    end
  end

  always_ff @(posedge clk) begin
    out_r     <= p3_r;
    out_g     <= p3_g;
    out_b     <= p3_b;
    out_class <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
  end

  assign out_valid = vld[3];

endmodule

@@ rtl/rgb_color_classifier.sv @@
// ----------------------------------------------------------------------------
// rgb_color_classifier
// conditions a raw rgb sensor sample and classifies its color
// ----------------------------------------------------------------------------
// Usage: drive raw_red, raw_green and raw_blue with start high for one cycle;
// the sample transfers at that edge (busy is low except during reset). One
// sample may enter every cycle.
// Each sample gives one result: done is high for exactly
// one cycle with cond_red, cond_green, cond_blue and color_class valid.
// The receiver cannot stall; results come out in input order.
// The pipeline has 3 stages of offset, gain and rescale
// setup, 2 stages of the restoring divider for the 250/max rescale, 5
// stages of band attenuation and 4 stages of xyz and window tests.
// Configuration: cfg_we with cfg_addr/cfg_wdata writes one register per
// cycle (0 red offset, 1 green offset, 2 blue offset, 3 red gain, 4 blue
// gain); other addresses are ignored. Write only while no sample is in flight.
// Reset clears the pipeline valid bits and loads offsets 0, red gain 5530 and
// blue gain 4096.
// ----------------------------------------------------------------------------
module rgb_color_classifier #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] raw_red,
  input  logic [15:0] raw_green,
  input  logic [15:0] raw_blue,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output logic        done,
  output logic signed [15:0] cond_red,
  output logic signed [15:0] cond_green,
  output logic signed [15:0] cond_blue,
  output logic [2:0]  color_class
);
  import rcc_pkg::*;

  logic [15:0] red_offset, green_offset, blue_offset, red_gain, blue_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_offset   <= '0;
      green_offset <= '0;
      blue_offset  <= '0;
      red_gain     <= RED_GAIN_RESET;
      blue_gain    <= BLUE_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RED_OFFSET:   red_offset   <= cfg_wdata;
        REG_GREEN_OFFSET: green_offset <= cfg_wdata;
        REG_BLUE_OFFSET:  blue_offset  <= cfg_wdata;
        REG_RED_GAIN:     red_gain     <= cfg_wdata;
        REG_BLUE_GAIN:    blue_gain    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic      front_valid;
  div_lane_t lane_r, lane_g, lane_b;
  logic [DEN_W-1:0] den;
  logic      scale;

  rcc_front #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start & ~busy),
    .raw_red      (raw_red),
    .raw_green    (raw_green),
    .raw_blue     (raw_blue),
    .red_offset   (red_offset),
    .green_offset (green_offset),
    .blue_offset  (blue_offset),
    .red_gain     (red_gain),
    .blue_gain    (blue_gain),
    .out_valid    (front_valid),
    .lane_r       (lane_r),
    .lane_g       (lane_g),
    .lane_b       (lane_b),
    .den          (den),
    .scale        (scale)
  );

  chan_t sc_r, sc_g, sc_b;
  logic [1:0] div_vld;

  rcc_div_lane u_div_r (.clk(clk), .lane(lane_r), .den(den), .scale(scale), .value(sc_r));
  rcc_div_lane u_div_g (.clk(clk), .lane(lane_g), .den(den), .scale(scale), .value(sc_g));
  rcc_div_lane u_div_b (.clk(clk), .lane(lane_b), .den(den), .scale(scale), .value(sc_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld <= '0;
    end else begin
      div_vld <= {div_vld[0], front_valid};
    end
  end

  logic  band_valid;
  chan_t bd_r, bd_g, bd_b;

  rcc_band u_band (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_vld[1]),
    .in_r      (sc_r),
    .in_g      (sc_g),
    .in_b      (sc_b),
    .out_valid (band_valid),
    .out_r     (bd_r),
    .out_g     (bd_g),
    .out_b     (bd_b)
  );

  color_class_t cls;

  rcc_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (band_valid),
    .in_r      (bd_r),
    .in_g      (bd_g),
    .in_b      (bd_b),
    .out_valid (done),
    .out_r     (cond_red),
    .out_g     (cond_green),
    .out_b     (cond_blue),
    .out_class (cls)
  );

  assign color_class = cls;

endmodule
